// File: hdl/ibt_pkg.sv
// Shared constants, types and codes for the interval booking table.
package ibt_pkg;

  localparam int unsigned MAX_BOOKINGS = 64;
  localparam int unsigned TIME_BITS    = 32;
  localparam int unsigned IDX_W        = $clog2(MAX_BOOKINGS);
  localparam int unsigned CNT_W        = $clog2(MAX_BOOKINGS + 1);

  typedef enum logic [1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } ibt_status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request, restart scan
    logic scan;    // walk the stored table
    logic finish;  // post result, append on success
  } ibt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ibt_sts_t;

endpackage

// File: hdl/ibt_if.sv
// Request and response channel interfaces.
interface ibt_req_if;
  import ibt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] slot_start;
  logic [TIME_BITS-1:0] slot_end;
  modport source (output valid, output slot_start, output slot_end, input ready);
  modport sink   (input valid, input slot_start, input slot_end, output ready);
endinterface

interface ibt_rsp_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [1:0] status;
  modport source (output valid, output accepted, output status, input ready);
  modport sink   (input valid, input accepted, input status, output ready);
endinterface

// File: hdl/interval_booking_table_top.sv
// Top level of the interval booking table.
//
//  channel | dir | payload                 | accepted when
//  --------+-----+-------------------------+---------------------------
//  req_i   | in  | slot_start, slot_end    | req_i.valid && req_i.ready
//  rsp_o   | out | accepted, status        | rsp_o.valid && rsp_o.ready
//
// One request at a time. With entries in the table, a request goes from accept
// to result in order: each stored entry (count = bookings held, up to 64) is
// read in turn through the single read port of the booking memory, its read
// register drains, the scan end is seen, and the controller decides. An empty
// table or an invalid interval skips the scan.
// The result sits in an output register; the next request is accepted
// while it waits. A stalled output holds the controller in its decide state.
// Reset (rst_ni low, async) empties the table; stored entries need no clear.
module interval_booking_table_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  ibt_req_if.sink   req_i,
  ibt_rsp_if.source rsp_o
);
  import ibt_pkg::*;

  ibt_cmd_t cmd;
  ibt_sts_t sts;

  ibt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ibt_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .slot_start_i (req_i.slot_start),
    .slot_end_i   (req_i.slot_end),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .accepted_o   (rsp_o.accepted),
    .status_o     (rsp_o.status)
  );

endmodule

// File: hdl/ibt_ctrl.sv
// Sequencing state machine: accept, scan table, post result.
module ibt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  ibt_pkg::ibt_sts_t sts_i,
  output ibt_pkg::ibt_cmd_t cmd_o
);
  import ibt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        // wait here until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

// File: hdl/ibt_datapath.sv
// Booking memory, scan compare, decision and output register.
module ibt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ibt_pkg::ibt_cmd_t             cmd_i,
  output ibt_pkg::ibt_sts_t             sts_o,
  input  logic [ibt_pkg::TIME_BITS-1:0] slot_start_i,
  input  logic [ibt_pkg::TIME_BITS-1:0] slot_end_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic                          accepted_o,
  output logic [1:0]                    status_o
);
  import ibt_pkg::*;

  logic [TIME_BITS-1:0] starts_mem [MAX_BOOKINGS];
  logic [TIME_BITS-1:0] ends_mem   [MAX_BOOKINGS];

  logic [TIME_BITS-1:0] s_q, e_q;
  logic [TIME_BITS-1:0] rd_start_q, rd_end_q;
  logic                 invalid_q, hit_q, rd_vld_q;
  logic [CNT_W-1:0]     idx_q, count_q;
  logic                 rsp_valid_q, accepted_q;
  ibt_status_e          status_q, status_d;

  logic rd_en, full, booked;

  assign rd_en  = cmd_i.scan && !invalid_q && (idx_q != count_q);
  assign full   = (count_q == CNT_W'(MAX_BOOKINGS));

  always_comb begin
    if (invalid_q)  status_d = ST_INVALID;
    else if (hit_q) status_d = ST_OVERLAP;
    else if (full)  status_d = ST_FULL;
    else            status_d = ST_BOOKED;
  end
  assign booked = (status_d == ST_BOOKED);

  assign sts_o.scan_done = invalid_q || ((idx_q == count_q) && !rd_vld_q);
  assign sts_o.out_free  = !rsp_valid_q || rsp_ready_i;

  // request capture and scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invalid_q <= 1'b0;
      hit_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      idx_q     <= '0;
    end else if (cmd_i.load) begin
      invalid_q <= (slot_end_i <= slot_start_i);
      hit_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      idx_q     <= '0;
    end else begin
      rd_vld_q <= rd_en;
      if (rd_en) idx_q <= idx_q + 1'b1;
      // half-open overlap: s < b and a < e
      if (rd_vld_q && (s_q < rd_end_q) && (rd_start_q < e_q)) hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q <= slot_start_i;
      e_q <= slot_end_i;
    end
  end

  // memory: one read port with registered data, one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_start_q <= starts_mem[idx_q[IDX_W-1:0]];
      rd_end_q   <= ends_mem[idx_q[IDX_W-1:0]];
    end
    if (cmd_i.finish && booked) begin
      starts_mem[count_q[IDX_W-1:0]] <= s_q;
      ends_mem[count_q[IDX_W-1:0]]   <= e_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        rsp_valid_q <= 1'b1;
        if (booked) count_q <= count_q + 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      accepted_q <= booked;
      status_q   <= status_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign accepted_o  = accepted_q;
  assign status_o    = status_q;

endmodule

// File: hdl/ibt_checker.sv
// Port-level checker for the interval booking table, with its bind.
module ibt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       accepted_i,
  input logic [1:0] status_i
);
  import ibt_pkg::*;

  logic       req_fire, rsp_fire;
  logic [1:0] pending_q;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // items in flight: one in work plus one in the output register at most
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pending_q <= '0;
    else         pending_q <= pending_q + {1'b0, req_fire} - {1'b0, rsp_fire};
  end

  a_accepted_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (accepted_i == (status_i == ST_BOOKED)))
    else $error("accepted flag disagrees with status");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(status_i)
                                       && $stable(accepted_i)))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_ready_i)
    else $error("second item taken while one is in work");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (pending_q != 2'd0))
    else $error("result without a pending item");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 2'd2)
    else $error("too many items in flight");

endmodule

bind interval_booking_table_top ibt_checker u_ibt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .accepted_i  (rsp_o.accepted),
  .status_i    (rsp_o.status)
);

// File: dv/ibt_booking_check.sv
// Booking predictor and response comparison for the interval booking table.
`timescale 1ns / 100ps
module ibt_booking_check (
  input  logic clk_i,
  input  logic rst_ni,
  ibt_req_if   req_i,
  ibt_rsp_if   rsp_o,
  output int   fail_count_o,
  output int   pending_o
);
  import ibt_pkg::*;

  typedef struct packed {
    logic        accepted;
    ibt_status_e status;
  } booking_result_t;

  logic [TIME_BITS-1:0] held_starts [MAX_BOOKINGS];
  logic [TIME_BITS-1:0] held_ends   [MAX_BOOKINGS];
  int unsigned          held_count;
  booking_result_t      due_results [$];

  // Decide one request against the held bookings; append it when it fits.
  function automatic booking_result_t book_slot(input logic [TIME_BITS-1:0] s,
                                                input logic [TIME_BITS-1:0] e);
    booking_result_t r;
    logic            hit;
    int unsigned     i;
    hit = 1'b0;
    if (e <= s) begin
      r.status = ST_INVALID;
    end else begin
      for (i = 0; i < held_count; i++) begin
        if (s < held_ends[i] && held_starts[i] < e) hit = 1'b1;
      end
      if (hit) begin
        r.status = ST_OVERLAP;
      end else if (held_count >= MAX_BOOKINGS) begin
        r.status = ST_FULL;
      end else begin
        held_starts[held_count] = s;
        held_ends[held_count]   = e;
        held_count++;
        r.status = ST_BOOKED;
      end
    end
    r.accepted = (r.status == ST_BOOKED);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    booking_result_t want;
    if (!rst_ni) begin
      held_count = 0;
      due_results.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        due_results.insert(due_results.size(), book_slot(req_i.slot_start, req_i.slot_end));
      end
      if (rsp_o.valid && rsp_o.ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: accepted %0b status %0d", rsp_o.accepted, rsp_o.status);
          fail_count_o++;
        end else begin
          want = due_results.pop_front();
          if (rsp_o.accepted !== want.accepted) begin
            $error("accepted: expected %0b, actual %0b", want.accepted, rsp_o.accepted);
            fail_count_o++;
          end
          if (rsp_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_o.status);
            fail_count_o++;
          end
        end
      end
      pending_o <= due_results.size();
    end
  end

endmodule

// File: dv/interval_booking_table_top_tb.sv
// Stimulus and verdict for the interval booking table testbench.
`timescale 1ns / 100ps
module interval_booking_table_top_tb;
  import ibt_pkg::*;

  // Random requests after the directed ones.
  localparam int unsigned RANDOM_ITEMS  = 2000;
  // Extra drain time past the worst request latency.
  localparam int unsigned DRAIN_CYCLES  = 100;
  // The long receiver hold-off: after this many results, hold ready low.
  localparam int unsigned STALL_AFTER   = 20;
  localparam int unsigned STALL_CYCLES  = 400;
  // Time limit in ns, with ample margin over the slowest correct run.
  localparam longint      LIMIT_NS      = 10_000_000;
  // Recent requests kept as anchors for touching and overlapping requests.
  localparam int unsigned ANCHOR_DEPTH  = 128;

  logic clk_i;
  logic rst_ni;

  ibt_req_if req_ch ();
  ibt_rsp_if rsp_ch ();

  int          fail_count;
  int          pending_count;
  int unsigned items_sent;
  int unsigned results_taken;

  logic [TIME_BITS-1:0] anchor_starts [$];
  logic [TIME_BITS-1:0] anchor_ends   [$];

  interval_booking_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  ibt_booking_check booking_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_o        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  // Per-item random wait. Every fourth window of 100 items runs
  // with no idling at all, so back-to-back traffic is covered too.
  function automatic int unsigned draw_gap(input int unsigned n);
    if ((n / 100) % 4 == 3) return 0;
    return $urandom_range(0, 10);
  endfunction

  // Offer one request and hold it until the block takes it. valid is only
  // dropped when a gap follows, so a back-to-back item never sees valid
  // lowered and raised in the same step.
  task automatic offer_slot(input logic [TIME_BITS-1:0] s, input logic [TIME_BITS-1:0] e);
    int unsigned gap;
    gap = draw_gap(items_sent);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.slot_start <= s;
    req_ch.slot_end   <= e;
    do @(posedge clk_i); while (!req_ch.ready);
    items_sent++;
    anchor_starts.insert(anchor_starts.size(), s);
    anchor_ends.insert(anchor_ends.size(), e);
    if (anchor_starts.size() > ANCHOR_DEPTH) begin
      void'(anchor_starts.pop_front());
      void'(anchor_ends.pop_front());
    end
  endtask

  // One random request. Most are built around earlier requests (touching
  // either end, overlapping by one, exact repeat, inside, covering) since
  // those are the cases that tell overlap from touch. A few are fresh short
  // slots that fill the table; once it is full they exercise the full-table
  // refusal. The rest are reversed or empty intervals and raw noise.
  task automatic offer_random_slot();
    int unsigned          pick;
    int unsigned          len;
    int unsigned          k;
    logic [TIME_BITS-1:0] a;
    logic [TIME_BITS-1:0] b;
    logic [TIME_BITS-1:0] s;
    logic [TIME_BITS-1:0] e;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(1, 50);
    if (pick < 6 || anchor_starts.size() == 0) begin
      s = $urandom;
      e = s + $urandom_range(1, 1000);
    end else if (pick < 76) begin
      k = $urandom_range(0, anchor_starts.size() - 1);
      a = anchor_starts[k];
      b = anchor_ends[k];
      case ($urandom_range(0, 7))
        0: begin s = a - len; e = a;         end  // ends where the anchor starts
        1: begin s = b;       e = b + len;   end  // starts where the anchor ends
        2: begin s = a - len; e = a + 1;     end  // one unit into the start
        3: begin s = b - 1;   e = b + len;   end  // one unit into the end
        4: begin s = a;       e = b;         end  // exact repeat
        5: begin s = a + (b - a) / 2; e = s + 1; end  // inside
        6: begin s = a - len; e = b + len;   end  // covering
        default: begin s = a; e = a + 1;     end  // same start, shortest
      endcase
    end else if (pick < 88) begin
      s = $urandom;
      e = $urandom_range(0, s);  // end <= start
    end else begin
      s = $urandom;
      e = $urandom;
    end
    offer_slot(s, e);
  endtask

  // Receiver: random ready gaps per result, plus one long hold-off so the
  // output register fills, the controller parks in its decide state and the
  // request side backs up while the sender keeps offering.
  initial begin
    int unsigned hold;
    rsp_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = (results_taken == STALL_AFTER) ? STALL_CYCLES : draw_gap(results_taken);
      if (hold != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      results_taken++;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.slot_start = '0;
    req_ch.slot_end   = '0;
    items_sent        = 0;
    results_taken     = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Invalid intervals: empty at both extremes and near zero, reversed.
    offer_slot(32'd0,          32'd0);
    offer_slot(32'd5,          32'd5);
    offer_slot(32'hFFFF_FFFF,  32'hFFFF_FFFF);
    offer_slot(32'hFFFF_FFFF,  32'd0);
    offer_slot(32'd100,        32'd50);
    // Bookings at the extremes and the middle of the time range.
    offer_slot(32'd0,          32'd1);
    offer_slot(32'hFFFF_FFFE,  32'hFFFF_FFFF);
    offer_slot(32'h7FFF_FFFF,  32'h8000_0000);
    // Whole range and an exact repeat both overlap.
    offer_slot(32'd0,          32'hFFFF_FFFF);
    offer_slot(32'd0,          32'd1);
    // Touching ends are allowed on either side.
    offer_slot(32'd1,          32'd2);
    offer_slot(32'd1000,       32'd2000);
    offer_slot(32'd2000,       32'd3000);
    offer_slot(32'd900,        32'd1000);
    offer_slot(32'd3000,       32'd3001);
    // Overlaps: straddling a boundary, contained, containing, last unit.
    offer_slot(32'd1999,       32'd2001);
    offer_slot(32'd950,        32'd1050);
    offer_slot(32'd1500,       32'd1600);
    offer_slot(32'd800,        32'd3100);
    offer_slot(32'd2999,       32'd3000);

    repeat (RANDOM_ITEMS) offer_random_slot();
    req_ch.valid <= 1'b0;

    // pending_count is registered, so look at least once past the last accept.
    do @(posedge clk_i); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_count != 0) $error("%0d results never arrived", pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ibt_pkg.sv
hdl/ibt_if.sv
hdl/ibt_ctrl.sv
hdl/ibt_datapath.sv
hdl/interval_booking_table_top.sv
hdl/ibt_checker.sv
dv/ibt_booking_check.sv
dv/interval_booking_table_top_tb.sv
